// ----- design/sps_pkg.sv -----
// Shared types, constants and helper functions of the slab page slot bitmap.
// Used by sps_ctrl, sps_dpath and slab_page_slot_bitmap; no dependencies.
`timescale 1ns / 1ps

package sps_pkg;

  localparam int MAX_SLOTS     = 512;
  localparam int MAP_WORD_BITS = 64;
  localparam int MAP_WORDS     = (MAX_SLOTS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WORD_IDX_W    = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W     = $clog2(MAP_WORD_BITS);
  localparam int NW_W          = WORD_IDX_W + 1;

  localparam int KIND_W     = 2;
  localparam int OFFSET_W   = 9;
  localparam int SLOT_IDX_W = 9;
  localparam int SLOTS_W    = 10;
  localparam int SIZE_W     = 8;
  localparam int HDR_W      = 9;
  localparam int DIV_CNT_W  = $clog2(SLOT_IDX_W + 1);
  localparam int PROD_W     = SLOT_IDX_W + SIZE_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_PAGE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_WORDS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_WORDS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDS_POINTERS = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MARK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

  typedef logic [MAP_WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [OFFSET_W-1:0] word_offset;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [OFFSET_W-1:0]   slot_word_offset;
    logic                  newly_marked;
    logic                  needs_scan;
    logic                  page_full;
    logic [SLOTS_W-1:0]    free_left;
    logic                  fault;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_step;
    logic div_init;
    logic div_step;
    logic mark_apply;
    logic clear_all;
    logic set_fault;
    logic mul;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              free_zero;
    logic              below_hdr;
    logic              avail_here;
    logic              scan_last;
    logic              div_done;
    logic              out_free;
  } sts_t;

  // bits of map word w that belong to real slots
  function automatic word_t valid_mask(input logic [WORD_IDX_W-1:0] w,
                                       input logic [SLOTS_W-1:0] slots);
    logic [SLOTS_W-1:0] start;
    logic [SLOTS_W-1:0] n;
    word_t              m;
    start = SLOTS_W'({w, {BIT_IDX_W{1'b0}}});
    n     = slots - start;
    if (start >= slots) begin
      m = '0;
    end else if (n >= SLOTS_W'(MAP_WORD_BITS)) begin
      m = '1;
    end else begin
      m = (word_t'(1) << n[BIT_IDX_W-1:0]) - word_t'(1);
    end
    return m;
  endfunction

  function automatic logic [BIT_IDX_W-1:0] lowest_bit(input word_t v);
    logic [BIT_IDX_W-1:0] b;
    b = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        b = BIT_IDX_W'(i);
      end
    end
    return b;
  endfunction

endpackage

// ----- design/slab_page_slot_bitmap.sv -----
// Top level of the slab page slot bitmap: sps_ctrl sequences sps_dpath.
// Alloc searches 1 to 8 map words from the hint; mark is set by the 9-step shift-subtract
// divider. One item at a time: in_stall stays high until the result is loaded for output.
// A result waiting in the output register does not block the next transfer in.
// Reset is synchronous: all slots read as used, free count and search hint zero,
// registers return to 512 slots, slot size 1, header 0, no pointers.
`timescale 1ns / 1ps

module slab_page_slot_bitmap (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sps_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sps_pkg::out_item_t             out_data
);

  sps_pkg::cmd_t cmd;
  sps_pkg::sts_t sts;

  sps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sps_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- design/sps_ctrl.sv -----
// Sequencing state machine of the slab page slot bitmap.
// Drives sps_pkg::cmd_t to sps_dpath and reads back sps_pkg::sts_t.
`timescale 1ns / 1ps

module sps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sps_pkg::sts_t sts,
  output sps_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_MARK   = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.kind)
          sps_pkg::KIND_ALLOC: begin
            if (sts.free_zero) begin
              cmd.set_fault = 1'b1;
              state_nxt     = S_MUL;
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end
          end
          sps_pkg::KIND_MARK: begin
            if (sts.below_hdr) begin
              cmd.set_fault = 1'b1;
              state_nxt     = S_MUL;
            end else begin
              cmd.div_init = 1'b1;
              state_nxt    = S_DIV;
            end
          end
          sps_pkg::KIND_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_nxt     = S_MUL;
          end
          default: begin
            cmd.set_fault = 1'b1;
            state_nxt     = S_MUL;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.avail_here) begin
          state_nxt = S_MUL;
        end else if (sts.scan_last) begin
          cmd.set_fault = 1'b1;
          state_nxt     = S_MUL;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_MARK;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_MARK: begin
        cmd.mark_apply = 1'b1;
        state_nxt      = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/sps_dpath.sv -----
// Datapath of the slab page slot bitmap: config registers, bitmap words, search,
// divider, offset multiply and output register. Uses sps_pkg types and functions.
`timescale 1ns / 1ps

module sps_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sps_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  sps_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sps_pkg::out_item_t                 out_data,
  input  sps_pkg::cmd_t                      cmd,
  output sps_pkg::sts_t                      sts
);

  logic [sps_pkg::SLOTS_W-1:0]    slots_cfg_r;
  logic [sps_pkg::SIZE_W-1:0]     size_cfg_r;
  logic [sps_pkg::HDR_W-1:0]      hdr_cfg_r;
  logic                           ptrs_cfg_r;

  sps_pkg::word_t                 map_r [sps_pkg::MAP_WORDS];
  logic [sps_pkg::WORD_IDX_W-1:0] hint_r;
  logic [sps_pkg::SLOTS_W-1:0]    free_count_r;

  logic [sps_pkg::KIND_W-1:0]     kind_r;
  logic [sps_pkg::OFFSET_W-1:0]   woff_r;
  logic [sps_pkg::WORD_IDX_W-1:0] ptr_r;
  logic [sps_pkg::WORD_IDX_W-1:0] step_r;

  logic [sps_pkg::SLOT_IDX_W-1:0] div_q_r;
  logic [sps_pkg::SIZE_W-1:0]     div_rem_r;
  logic [sps_pkg::DIV_CNT_W-1:0]  div_cnt_r;

  logic [sps_pkg::SLOT_IDX_W-1:0] idx_r;
  logic [sps_pkg::OFFSET_W-1:0]   offs_r;
  logic                           newly_r;
  logic                           scan_r;
  logic                           fault_r;
  logic                           has_slot_r;

  logic                           out_valid_r;
  sps_pkg::out_item_t             out_data_r;

  logic [sps_pkg::SLOTS_W-1:0]    slots_eff;
  logic [sps_pkg::SIZE_W-1:0]     size_eff;
  logic [sps_pkg::NW_W-1:0]       nw;
  logic [sps_pkg::WORD_IDX_W-1:0] nw_m1;
  logic [sps_pkg::WORD_IDX_W-1:0] rd_addr;
  sps_pkg::word_t                 rd_word;
  sps_pkg::word_t                 avail;
  logic [sps_pkg::BIT_IDX_W-1:0]  avail_bit;
  logic [sps_pkg::BIT_IDX_W-1:0]  mark_bit;
  logic                           mark_fault;
  logic [sps_pkg::SIZE_W:0]       rem_sh;
  logic                           div_bit;
  logic [sps_pkg::SIZE_W:0]       rem_sub;
  logic [sps_pkg::PROD_W-1:0]     offs_sum;

  always_comb begin
    if (slots_cfg_r == '0) begin
      slots_eff = sps_pkg::SLOTS_W'(1);
    end else if (slots_cfg_r > sps_pkg::SLOTS_W'(sps_pkg::MAX_SLOTS)) begin
      slots_eff = sps_pkg::SLOTS_W'(sps_pkg::MAX_SLOTS);
    end else begin
      slots_eff = slots_cfg_r;
    end
  end

  assign size_eff = (size_cfg_r == '0) ? sps_pkg::SIZE_W'(1) : size_cfg_r;
  assign nw = sps_pkg::NW_W'((slots_eff + sps_pkg::SLOTS_W'(sps_pkg::MAP_WORD_BITS - 1))
                             >> sps_pkg::BIT_IDX_W);
  assign nw_m1 = sps_pkg::WORD_IDX_W'(nw - sps_pkg::NW_W'(1));

  assign rd_addr   = cmd.mark_apply ? div_q_r[sps_pkg::SLOT_IDX_W-1 -: sps_pkg::WORD_IDX_W]
                                    : ptr_r;
  assign rd_word   = map_r[rd_addr];
  assign avail     = ~rd_word & sps_pkg::valid_mask(ptr_r, slots_eff);
  assign avail_bit = sps_pkg::lowest_bit(avail);
  assign mark_bit  = div_q_r[sps_pkg::BIT_IDX_W-1:0];
  assign mark_fault = ({1'b0, div_q_r} >= slots_eff);

  assign rem_sh  = {div_rem_r, div_q_r[sps_pkg::SLOT_IDX_W-1]};
  assign div_bit = (rem_sh >= {1'b0, size_eff});
  assign rem_sub = rem_sh - {1'b0, size_eff};

  assign offs_sum = sps_pkg::PROD_W'(idx_r) * sps_pkg::PROD_W'(size_eff)
                  + sps_pkg::PROD_W'(hdr_cfg_r);

  assign sts.kind       = kind_r;
  assign sts.free_zero  = (free_count_r == '0);
  assign sts.below_hdr  = (woff_r < hdr_cfg_r);
  assign sts.avail_here = (avail != '0);
  assign sts.scan_last  = (step_r == nw_m1);
  assign sts.div_done   = (div_cnt_r == sps_pkg::DIV_CNT_W'(sps_pkg::SLOT_IDX_W));
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_cfg_r <= sps_pkg::SLOTS_W'(sps_pkg::MAX_SLOTS);
      size_cfg_r  <= sps_pkg::SIZE_W'(1);
      hdr_cfg_r   <= '0;
      ptrs_cfg_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sps_pkg::CFG_SLOTS_IN_PAGE:  slots_cfg_r <= cfg_data;
        sps_pkg::CFG_SLOT_WORDS:     size_cfg_r  <= cfg_data[sps_pkg::SIZE_W-1:0];
        sps_pkg::CFG_HEADER_WORDS:   hdr_cfg_r   <= cfg_data[sps_pkg::HDR_W-1:0];
        sps_pkg::CFG_HOLDS_POINTERS: ptrs_cfg_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // bitmap, hint and free count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < sps_pkg::MAP_WORDS; w++) begin
        map_r[w] <= '1;
      end
      hint_r       <= '0;
      free_count_r <= '0;
    end else if (cmd.clear_all) begin
      for (int w = 0; w < sps_pkg::MAP_WORDS; w++) begin
        map_r[w] <= ~sps_pkg::valid_mask(sps_pkg::WORD_IDX_W'(w), slots_eff);
      end
      free_count_r <= slots_eff;
    end else if (cmd.scan_step && sts.avail_here) begin
      map_r[ptr_r][avail_bit] <= 1'b1;
      hint_r                  <= ptr_r;
      free_count_r            <= free_count_r - sps_pkg::SLOTS_W'(1);
    end else if (cmd.mark_apply && !mark_fault && !rd_word[mark_bit]) begin
      map_r[rd_addr][mark_bit] <= 1'b1;
      if (free_count_r != '0) begin
        free_count_r <= free_count_r - sps_pkg::SLOTS_W'(1);
      end
    end
  end

  // item, search pointer, divider and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r     <= in_data.kind;
      woff_r     <= in_data.word_offset;
      idx_r      <= '0;
      newly_r    <= 1'b0;
      scan_r     <= 1'b0;
      fault_r    <= 1'b0;
      has_slot_r <= 1'b0;
    end
    if (cmd.set_fault) begin
      fault_r <= 1'b1;
    end
    if (cmd.scan_init) begin
      ptr_r  <= ({1'b0, hint_r} < nw) ? hint_r : '0;
      step_r <= '0;
    end else if (cmd.scan_step) begin
      if (sts.avail_here) begin
        idx_r      <= {ptr_r, avail_bit};
        has_slot_r <= 1'b1;
      end else begin
        ptr_r  <= (ptr_r == nw_m1) ? '0 : ptr_r + sps_pkg::WORD_IDX_W'(1);
        step_r <= step_r + sps_pkg::WORD_IDX_W'(1);
      end
    end
    if (cmd.div_init) begin
      div_q_r   <= sps_pkg::SLOT_IDX_W'(woff_r - hdr_cfg_r);
      div_rem_r <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_q_r   <= {div_q_r[sps_pkg::SLOT_IDX_W-2:0], div_bit};
      div_rem_r <= div_bit ? rem_sub[sps_pkg::SIZE_W-1:0] : rem_sh[sps_pkg::SIZE_W-1:0];
      div_cnt_r <= div_cnt_r + sps_pkg::DIV_CNT_W'(1);
    end
    if (cmd.mark_apply) begin
      if (mark_fault) begin
        fault_r <= 1'b1;
      end else begin
        idx_r      <= div_q_r;
        has_slot_r <= 1'b1;
        if (!rd_word[mark_bit]) begin
          newly_r <= 1'b1;
          scan_r  <= ptrs_cfg_r;
        end
      end
    end
    if (cmd.mul) begin
      if (!has_slot_r) begin
        offs_r <= '0;
      end else if (offs_sum > sps_pkg::PROD_W'(sps_pkg::OFFSET_MAX)) begin
        offs_r <= sps_pkg::OFFSET_MAX;
      end else begin
        offs_r <= offs_sum[sps_pkg::OFFSET_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.slot_index       <= idx_r;
      out_data_r.slot_word_offset <= offs_r;
      out_data_r.newly_marked     <= newly_r;
      out_data_r.needs_scan       <= scan_r;
      out_data_r.page_full        <= (free_count_r == '0);
      out_data_r.free_left        <= free_count_r;
      out_data_r.fault            <= fault_r;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && out_stall))
    else $error("result loaded over an untaken transfer");

  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step && sts.avail_here) |=>
      (free_count_r == $past(free_count_r) - sps_pkg::SLOTS_W'(1)))
    else $error("alloc did not take one free slot");

  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_all |=> (free_count_r == $past(slots_eff)))
    else $error("clear left wrong free count");

  a_fault_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.fault) |->
      (out_data_r.slot_index == '0 && out_data_r.slot_word_offset == '0))
    else $error("faulted result carries a slot");

endmodule
